/* src/char_lcd_command_sequencer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Character LCD command sequencer assertion macros
// Shared property forms for the checker of the sequencer unit.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLSU_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

// Next-cycle implication that is also checked during reset.
`define CLSU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");

`endif

/* src/clsu_pkg.sv */
// ----------------------------------------------------------------------------
// Character LCD command sequencer package
// Request and transfer types, command codes and the power-up sequence table.
// ----------------------------------------------------------------------------
`default_nettype none

package clsu_pkg;

    localparam int GLYPH_ROWS  = 8;
    localparam int INIT_LEN    = 7;
    localparam int GLYPH_LEN   = GLYPH_ROWS + 2;
    localparam int STEP_W      = $clog2(GLYPH_LEN);
    localparam int INIT_IDX_W  = $clog2(INIT_LEN);
    localparam int ROW_IDX_W   = $clog2(GLYPH_ROWS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [2:0] CMD_INIT       = 3'd0;
    localparam logic [2:0] CMD_CLEAR      = 3'd1;
    localparam logic [2:0] CMD_GOTO       = 3'd2;
    localparam logic [2:0] CMD_WRITE_AT   = 3'd3;
    localparam logic [2:0] CMD_WRITE_NEXT = 3'd4;
    localparam logic [2:0] CMD_GLYPH      = 3'd5;

    localparam logic [7:0] SET_DDRAM     = 8'h80;
    localparam logic [7:0] SET_CGRAM     = 8'h40;
    localparam logic [7:0] CLEAR_DISPLAY = 8'h01;

    typedef enum logic [2:0] {
        OP_INIT,
        OP_CLEAR,
        OP_GOTO,
        OP_WRITE_AT,
        OP_WRITE_NEXT,
        OP_GLYPH
    } op_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        row;
        logic [5:0]  col;
        logic [7:0]  char_code;
        logic [2:0]  glyph_index;
        logic [63:0] glyph_rows;
    } req_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       poll_busy;
        logic [4:0] delay_before_ms;
        logic [3:0] delay_after_ms;
        logic       last;
    } txn_t;

    typedef struct packed {
        op_t                  op;
        logic [7:0]           addr_byte;
        logic [7:0]           char_code;
        logic [63:0]          glyph_rows;
        logic [STEP_W-1:0]    last_step;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic txn_t init_txn(input logic [INIT_IDX_W-1:0] idx);
        txn_t t;
        t = '0;
        unique case (idx)
            3'd0: begin
                t.bus_byte        = 8'h30;
                t.delay_before_ms = 5'd16;
                t.delay_after_ms  = 4'd5;
            end
            3'd1: begin
                t.bus_byte       = 8'h30;
                t.delay_after_ms = 4'd1;
            end
            3'd2: begin
                t.bus_byte       = 8'h30;
                t.delay_after_ms = 4'd1;
            end
            3'd3: begin
                t.bus_byte       = 8'h38;
                t.delay_after_ms = 4'd4;
            end
            3'd4: begin
                t.bus_byte        = 8'h0C;
                t.delay_before_ms = 5'd4;
                t.delay_after_ms  = 4'd4;
            end
            3'd5: begin
                t.bus_byte       = 8'h01;
                t.delay_after_ms = 4'd4;
            end
            3'd6: begin
                t.bus_byte       = 8'h06;
                t.delay_after_ms = 4'd4;
            end
            default: begin
                t = '0;
            end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

/* src/clsu_front.sv */
// ----------------------------------------------------------------------------
// Character LCD command sequencer front end
// Accepts requests, classifies them and writes a descriptor into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module clsu_front (
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire clsu_pkg::req_t         s_payload,
    input  wire clsu_pkg::queue_status_t q_status,
    output logic                        q_wr_en,
    output clsu_pkg::desc_t             q_wr_desc
);
    import clsu_pkg::*;

    logic known_cmd;

    assign s_ready = !q_status.full;

    always_comb begin
        known_cmd           = 1'b1;
        q_wr_desc.op        = OP_INIT;
        q_wr_desc.addr_byte = SET_DDRAM | {1'b0, s_payload.row, s_payload.col};
        q_wr_desc.char_code = s_payload.char_code;
        q_wr_desc.glyph_rows = s_payload.glyph_rows;
        q_wr_desc.last_step = '0;
        unique case (s_payload.cmd)
            CMD_INIT: begin
                q_wr_desc.op        = OP_INIT;
                q_wr_desc.last_step = STEP_W'(INIT_LEN - 1);
            end
            CMD_CLEAR: begin
                q_wr_desc.op = OP_CLEAR;
            end
            CMD_GOTO: begin
                q_wr_desc.op = OP_GOTO;
            end
            CMD_WRITE_AT: begin
                q_wr_desc.op        = OP_WRITE_AT;
                q_wr_desc.last_step = STEP_W'(1);
            end
            CMD_WRITE_NEXT: begin
                q_wr_desc.op = OP_WRITE_NEXT;
            end
            CMD_GLYPH: begin
                q_wr_desc.op        = OP_GLYPH;
                q_wr_desc.addr_byte = SET_CGRAM | {2'b00, s_payload.glyph_index, 3'b000};
                q_wr_desc.last_step = STEP_W'(GLYPH_LEN - 1);
            end
            default: begin
                known_cmd = 1'b0;
            end
        endcase
    end

    // Unused command codes are consumed without producing a descriptor.
    assign q_wr_en = s_valid && s_ready && known_cmd;

endmodule

`default_nettype wire

/* src/clsu_queue.sv */
// ----------------------------------------------------------------------------
// Character LCD command sequencer descriptor queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module clsu_queue (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    wr_en,
    input  wire clsu_pkg::desc_t         wr_desc,
    input  wire logic                    rd_pop,
    output clsu_pkg::desc_t              rd_desc,
    output clsu_pkg::queue_status_t      status
);
    import clsu_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_pop && !status.empty;
    assign rd_desc      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

`default_nettype wire

/* src/clsu_back.sv */
// ----------------------------------------------------------------------------
// Character LCD command sequencer back end
// Steps through each descriptor and emits one bus transfer per cycle while m_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module clsu_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire clsu_pkg::desc_t         q_desc,
    input  wire clsu_pkg::queue_status_t q_status,
    output logic                         q_pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output clsu_pkg::txn_t               m_payload
);
    import clsu_pkg::*;

    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    txn_t                 m_payload_reg;
    txn_t                 txn;
    logic                 load;
    logic                 final_step;
    logic [ROW_IDX_W-1:0] row_idx;

    assign final_step = (step_reg == q_desc.last_step);
    assign load       = !q_status.empty && (!m_valid_reg || m_ready);
    assign q_pop      = load && final_step;
    assign row_idx    = ROW_IDX_W'(step_reg - 1'b1);

    always_comb begin
        txn           = '0;
        txn.poll_busy = 1'b1;
        unique case (q_desc.op)
            OP_INIT: begin
                txn = init_txn(step_reg[INIT_IDX_W-1:0]);
            end
            OP_CLEAR: begin
                txn.bus_byte = CLEAR_DISPLAY;
            end
            OP_GOTO: begin
                txn.bus_byte = q_desc.addr_byte;
            end
            OP_WRITE_AT: begin
                if (step_reg == '0) begin
                    txn.bus_byte = q_desc.addr_byte;
                end else begin
                    txn.is_data  = 1'b1;
                    txn.bus_byte = q_desc.char_code;
                end
            end
            OP_WRITE_NEXT: begin
                txn.is_data  = 1'b1;
                txn.bus_byte = q_desc.char_code;
            end
            OP_GLYPH: begin
                if (step_reg == '0) begin
                    txn.bus_byte = q_desc.addr_byte;
                end else if (final_step) begin
                    txn.bus_byte = SET_DDRAM;
                end else begin
                    txn.is_data  = 1'b1;
                    txn.bus_byte = q_desc.glyph_rows[{row_idx, 3'b000} +: 8];
                end
            end
            default: begin
                txn = '0;
            end
        endcase
        txn.last = final_step;
    end

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
            step_next    = final_step ? '0 : step_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_payload_reg <= txn;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire

/* src/char_lcd_command_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Character LCD command sequencer unit
// Expands text display requests into runs of 8-bit LCD bus transfers.
//
// Requests arrive on the s_ channel as one packed request per transfer.
// Results leave on the m_ channel, one bus transaction per transfer, with
// last set on the final transaction of each request. Initialize yields 7
// transactions, define glyph 10, write char at position 2, the others 1;
// unused command codes are accepted and yield none.
// When the back end is free, the first transaction of a request is presented
// at the clock edge after the one that accepts the request. The back end
// steps through the head descriptor with one step counter and emits one
// transaction per cycle while m_ready stays high. A two-entry
// descriptor queue lets new requests be accepted while earlier ones
// are still being emitted.
// When the receiver stalls, the output register holds its transaction and
// the queue fills; s_ready drops only when both queue entries are taken.
// Reset clears the queue and the step counter and drops m_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_command_sequencer_unit (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire clsu_pkg::req_t  s_payload,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output clsu_pkg::txn_t       m_payload
);
    import clsu_pkg::*;

    queue_status_t q_status;
    logic          q_wr_en;
    desc_t         q_wr_desc;
    logic          q_pop;
    desc_t         q_rd_desc;

    clsu_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_status  (q_status),
        .q_wr_en   (q_wr_en),
        .q_wr_desc (q_wr_desc)
    );

    clsu_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_desc (q_wr_desc),
        .rd_pop  (q_pop),
        .rd_desc (q_rd_desc),
        .status  (q_status)
    );

    clsu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_desc    (q_rd_desc),
        .q_status  (q_status),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

`default_nettype wire

/* src/clsu_checker.sv */
// ----------------------------------------------------------------------------
// Character LCD command sequencer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_lcd_command_sequencer_unit_defines.svh"

module clsu_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           m_valid,
    input  wire logic           m_ready,
    input  wire clsu_pkg::txn_t m_payload
);
    import clsu_pkg::*;

    `CLSU_ASSERT_NEXT_ALWAYS(a_reset_drops_valid, aclk, !aresetn, !m_valid)
    `CLSU_ASSERT_NEXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_payload))
    `CLSU_ASSERT_IMPLY(a_polled_no_delay, aclk, aresetn, m_valid && m_payload.poll_busy, (m_payload.delay_before_ms == '0) && (m_payload.delay_after_ms == '0))
    `CLSU_ASSERT_IMPLY(a_data_polls, aclk, aresetn, m_valid && m_payload.is_data, m_payload.poll_busy)

endmodule

bind char_lcd_command_sequencer_unit clsu_checker u_clsu_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire
